### hw/rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, codes and vlq helpers for the midi track event encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int VLQ_MAX_BYTES = 4;
  localparam int CMD_BYTES     = 10;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [31:0] VLQ_LIMIT    = 32'h0FFF_FFFF;
  localparam logic [7:0]  STATUS_META  = 8'hFF;
  localparam logic [6:0]  META_END     = 7'h2F;
  localparam logic [7:0]  CHAN_MIN     = 8'h80;
  localparam logic [7:0]  CHAN_MAX     = 8'hEF;
  // 00 ff 2f 00, first byte in the low bits
  localparam logic [31:0] END_SEQ      = 32'h002F_FF00;
  localparam logic [2:0]  END_SEQ_LEN  = 3'd4;

  typedef enum logic [1:0] {
    FUNC_HEADER = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_END    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_META    = 2'd1,
    KIND_SYSEX   = 2'd2
  } kind_t;

  typedef enum logic {
    REG_RUNNING_STATUS = 1'b0,
    REG_AUTO_END       = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      err;
    logic [31:0]               tlen;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] vlq_groups(input logic [27:0] v);
    logic [2:0] g;
    if (|v[27:21]) g = 3'd4;
    else if (|v[20:14]) g = 3'd3;
    else if (|v[13:7]) g = 3'd2;
    else g = 3'd1;
    return g;
  endfunction

  function automatic logic [31:0] vlq_pack(input logic [27:0] v, input logic [2:0] g);
    logic [31:0] r;
    case (g)
      3'd2:    r = {16'h0, 1'b0, v[6:0], 1'b1, v[13:7]};
      3'd3:    r = {8'h0, 1'b0, v[6:0], 1'b1, v[13:7], 1'b1, v[20:14]};
      3'd4:    r = {1'b0, v[6:0], 1'b1, v[13:7], 1'b1, v[20:14], 1'b1, v[27:21]};
      default: r = {24'h0, 1'b0, v[6:0]};
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/mte_front.sv
// ----------------------------------------------------------------------------
// mte_front
// Classifies input beats, tracks running status and byte count, and builds
// one byte-sequence command per beat for the queue.
// ----------------------------------------------------------------------------
module mte_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [1:0]          kind,
  input  logic [31:0]         delta_time,
  input  logic [7:0]          status_byte,
  input  logic [6:0]          meta_kind,
  input  logic [31:0]         payload_length,
  input  logic [7:0]          data_byte,
  input  logic                running_status_enable,
  input  logic                auto_end_enable,
  input  mte_pkg::q_status_t  q_status,
  output logic                push,
  output mte_pkg::cmd_t       cmd
);

  localparam int SEQ_W = mte_pkg::CMD_BYTES * 8;

  logic [7:0]  last_status, last_status_next;
  logic [31:0] byte_count, byte_count_next;
  logic        ended, ended_next;

  logic        accept;
  logic [2:0]  dg, pg_full, pg;
  logic [1:0]  pc;
  logic [31:0] dv, pv;
  logic [15:0] pfx;
  logic        prefixed, drop, err;
  logic [5:0]  sh1, sh2;
  logic [SEQ_W-1:0] seq;
  logic [3:0]  hcount;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    dg      = mte_pkg::vlq_groups(delta_time[27:0]);
    pg_full = mte_pkg::vlq_groups(payload_length[27:0]);
    dv      = mte_pkg::vlq_pack(delta_time[27:0], dg);
    pv      = mte_pkg::vlq_pack(payload_length[27:0], pg_full);
    drop    = running_status_enable && (status_byte >= mte_pkg::CHAN_MIN) &&
              (status_byte <= mte_pkg::CHAN_MAX) && (status_byte == last_status);
    case (kind)
      mte_pkg::KIND_META: begin
        prefixed = 1'b1;
        pfx      = {1'b0, meta_kind, mte_pkg::STATUS_META};
        pc       = 2'd2;
      end
      mte_pkg::KIND_SYSEX: begin
        prefixed = 1'b1;
        pfx      = {8'h00, status_byte};
        pc       = 2'd1;
      end
      default: begin
        prefixed = 1'b0;
        pfx      = {8'h00, status_byte};
        pc       = drop ? 2'd0 : 2'd1;
      end
    endcase
    pg     = prefixed ? pg_full : 3'd0;
    err    = (delta_time > mte_pkg::VLQ_LIMIT) ||
             (prefixed && (payload_length > mte_pkg::VLQ_LIMIT));
    sh1    = {dg, 3'b000};
    sh2    = {3'(dg + {1'b0, pc}), 3'b000};
    seq    = SEQ_W'(dv) | (SEQ_W'(pfx) << sh1) | (SEQ_W'(pv) << sh2);
    hcount = 4'(dg) + 4'(pc) + 4'(pg);
  end

  always_comb begin
    cmd              = '0;
    push             = 1'b0;
    last_status_next = last_status;
    byte_count_next  = byte_count;
    ended_next       = ended;
    case (func)
      mte_pkg::FUNC_HEADER: begin
        push = accept;
        if (err) begin
          cmd.err = 1'b1;
        end else begin
          cmd.bytes = seq;
          cmd.count = hcount;
          if (accept) begin
            byte_count_next = byte_count + 32'(hcount);
            case (kind)
              mte_pkg::KIND_META: begin
                last_status_next = 8'h00;
                ended_next       = (meta_kind == mte_pkg::META_END);
              end
              mte_pkg::KIND_SYSEX: begin
                last_status_next = 8'h00;
                ended_next       = 1'b0;
              end
              default: begin
                if (!drop) last_status_next = status_byte;
                ended_next = 1'b0;
              end
            endcase
          end
        end
      end
      mte_pkg::FUNC_DATA: begin
        push      = accept;
        cmd.bytes = SEQ_W'(data_byte);
        cmd.count = 4'd1;
        if (accept) byte_count_next = byte_count + 32'd1;
      end
      mte_pkg::FUNC_END: begin
        push = accept;
        if (auto_end_enable && !ended) begin
          cmd.bytes = SEQ_W'(mte_pkg::END_SEQ);
          cmd.count = 4'(mte_pkg::END_SEQ_LEN);
          cmd.tlen  = byte_count + 32'(mte_pkg::END_SEQ_LEN);
        end else begin
          cmd.tlen  = byte_count;
        end
        if (accept) begin
          last_status_next = 8'h00;
          byte_count_next  = 32'd0;
          ended_next       = 1'b0;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_status <= 8'h00;
      byte_count  <= 32'd0;
      ended       <= 1'b0;
    end else begin
      last_status <= last_status_next;
      byte_count  <= byte_count_next;
      ended       <= ended_next;
    end
  end

endmodule

### hw/rtl/mte_queue.sv
// ----------------------------------------------------------------------------
// mte_queue
// Small command queue between the front classifier and the back serializer.
// ----------------------------------------------------------------------------
module mte_queue #(
  parameter int DEPTH = mte_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mte_pkg::cmd_t      wr_cmd,
  input  logic               pop,
  output mte_pkg::cmd_t      rd_cmd,
  output mte_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mte_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push, do_pop;

  assign status.full  = (cnt == CNT_FULL);
  assign status.empty = (cnt == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_cmd       = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

### hw/rtl/mte_back.sv
// ----------------------------------------------------------------------------
// mte_back
// Walks the head command one byte per beat into a registered output stage.
// ----------------------------------------------------------------------------
module mte_back (
  input  logic               clk,
  input  logic               rst,
  input  mte_pkg::cmd_t      head,
  input  mte_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [31:0]        track_length,
  output logic               error
);

  logic [3:0] idx;
  logic       load, have, res_last, res_real;

  assign load     = !out_valid || out_ready;
  assign have     = !q_status.empty;
  assign res_real = (head.count != 4'd0);
  assign res_last = !res_real || (idx == head.count - 4'd1);
  assign pop      = load && have && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (load) begin
      out_valid <= have;
      if (have) idx <= res_last ? 4'd0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && have) begin
      out_byte     <= res_real ? head.bytes[idx] : 8'h00;
      byte_valid   <= res_real;
      last         <= res_last;
      track_length <= res_last ? head.tlen : 32'd0;
      error        <= head.err;
    end
  end

endmodule

### hw/rtl/midi_track_event_encoder.sv
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Serializes a standard midi file track body, one byte per output beat.
// ----------------------------------------------------------------------------
// The front accepts one input beat per cycle while the command queue has room;
// the back emits one output beat per cycle from its output register while the
// sink is ready and the queue is not empty. A data byte yields one beat, an
// event header one beat per emitted byte (1 to 10: delta vlq, prefix, length
// vlq), an end of track one or four beats, a rejected header one empty beat.
// Sustained throughput is set by the byte-wide back output register. Each
// input beat's final result carries tlast; track_length is nonzero only there.
module midi_track_event_encoder #(
  parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // delta_time, status_byte, meta_kind, payload_length, data_byte, pad
  input  logic [87:0] s_tdata,
  // func, kind
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte, track_length
  output logic [39:0] m_tdata,
  // byte_valid, error
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               running_status_enable, auto_end_enable;
  logic               push, pop;
  mte_pkg::cmd_t      wr_cmd, rd_cmd;
  mte_pkg::q_status_t q_status;
  logic [7:0]         out_byte;
  logic [31:0]        track_length;
  logic               byte_valid, error;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mte_pkg::REG_AUTO_END) ? {31'd0, auto_end_enable}
                                                      : {31'd0, running_status_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status_enable <= 1'b1;
      auto_end_enable       <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        mte_pkg::REG_RUNNING_STATUS: running_status_enable <= pwdata[0];
        mte_pkg::REG_AUTO_END:       auto_end_enable       <= pwdata[0];
        default:                     running_status_enable <= running_status_enable;
      endcase
    end
  end

  mte_front u_front (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (s_tvalid),
    .in_ready              (s_tready),
    .func                  (s_tuser[1:0]),
    .kind                  (s_tuser[3:2]),
    .delta_time            (s_tdata[31:0]),
    .status_byte           (s_tdata[39:32]),
    .meta_kind             (s_tdata[46:40]),
    .payload_length        (s_tdata[78:47]),
    .data_byte             (s_tdata[86:79]),
    .running_status_enable (running_status_enable),
    .auto_end_enable       (auto_end_enable),
    .q_status              (q_status),
    .push                  (push),
    .cmd                   (wr_cmd)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .status (q_status)
  );

  mte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (rd_cmd),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (m_tlast),
    .track_length (track_length),
    .error        (error)
  );

  assign m_tdata = {track_length, out_byte};
  assign m_tuser = {error, byte_valid};

  // rejected header: single empty beat
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata[39:8] == 32'd0))
    else $error("error beat not a lone empty result");

  // track length only on the closing beat
  a_tlen_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:8] != 32'd0) |-> m_tlast)
    else $error("track length outside last beat");

  // empty beats carry a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] == 8'h00) && m_tlast)
    else $error("empty beat with data");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue overflow");

endmodule
